[hw/rtl/rotated_clipped_line_raster_defines.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef ROTATED_CLIPPED_LINE_RASTER_DEFINES_SVH
`define ROTATED_CLIPPED_LINE_RASTER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RCLR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define RCLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/rclr_pkg.sv]
`timescale 1ns / 1ps

package rclr_pkg;

	localparam int COORD_W       = 16;
	localparam int DELTA_W       = 17;
	localparam int ERR_W         = 19;
	localparam int GRAY_W        = 8;
	localparam int PANEL_COORD_W = 10;
	// panel mapping width: holds PANEL_WIDTH-1-y for any 16-bit y
	localparam int MAP_W         = 18;

	localparam int PANEL_WIDTH_DEF  = 960;
	localparam int PANEL_HEIGHT_DEF = 540;

	localparam logic [GRAY_W-1:0] GRAY_MASK = 8'hF0;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [PANEL_COORD_W-1:0] panel_x;
		logic [PANEL_COORD_W-1:0] panel_y;
		logic [GRAY_W-1:0]        gray;
		logic                     on_panel;
		logic                     last;
	} pixel_t;

endpackage

[hw/rtl/rclr_panel_map.sv]
`timescale 1ns / 1ps

module rclr_panel_map #(
	parameter int PANEL_WIDTH  = rclr_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = rclr_pkg::PANEL_HEIGHT_DEF
) (
	input  logic signed [rclr_pkg::COORD_W-1:0] cur_x,
	input  logic signed [rclr_pkg::COORD_W-1:0] cur_y,
	input  logic        [rclr_pkg::GRAY_W-1:0]  line_gray,
	input  logic                                last,
	output rclr_pkg::pixel_t                    pixel
);

	localparam int MW = rclr_pkg::MAP_W;
	localparam int PW = rclr_pkg::PANEL_COORD_W;
	localparam logic signed [MW-1:0] PW_S  = MW'(PANEL_WIDTH);
	localparam logic signed [MW-1:0] PW_M1 = MW'(PANEL_WIDTH - 1);
	localparam logic signed [MW-1:0] PH_S  = MW'(PANEL_HEIGHT);

	logic signed [MW-1:0] px;
	logic signed [MW-1:0] py;
	logic                 on;

	// rotated panel: column = WIDTH-1-y, row = x
	assign px = PW_M1 - MW'(cur_y);
	assign py = MW'(cur_x);
	assign on = (px >= 0) && (px < PW_S) && (py >= 0) && (py < PH_S);

	always_comb begin
		pixel.panel_x  = on ? px[PW-1:0] : '0;
		pixel.panel_y  = on ? py[PW-1:0] : '0;
		pixel.gray     = line_gray & rclr_pkg::GRAY_MASK;
		pixel.on_panel = on;
		pixel.last     = last;
	end

endmodule

[hw/rtl/rotated_clipped_line_raster.sv]
`timescale 1ns / 1ps
// An accepted word updates the stage 1 line state; its pixel is then mapped and registered on the output register.
// Throughput: one word per cycle while in_stall is low; the error-term update is combinational.
// in_stall rises only while a finished pixel is held behind a stalled output.
// Reset (arst_n low, asynchronous): line idle, all line state zero, no pixel pending.
module rotated_clipped_line_raster #(
	parameter int PANEL_WIDTH  = rclr_pkg::PANEL_WIDTH_DEF,
	parameter int PANEL_HEIGHT = rclr_pkg::PANEL_HEIGHT_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic                                      command,
	input  logic signed [rclr_pkg::COORD_W-1:0]       start_x,
	input  logic signed [rclr_pkg::COORD_W-1:0]       start_y,
	input  logic signed [rclr_pkg::COORD_W-1:0]       end_x,
	input  logic signed [rclr_pkg::COORD_W-1:0]       end_y,
	input  logic        [rclr_pkg::GRAY_W-1:0]        color,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic        [rclr_pkg::PANEL_COORD_W-1:0] panel_x,
	output logic        [rclr_pkg::PANEL_COORD_W-1:0] panel_y,
	output logic        [rclr_pkg::GRAY_W-1:0]        gray,
	output logic                                      on_panel,
	output logic                                      last
);

	`include "rotated_clipped_line_raster_defines.svh"

	localparam int CW = rclr_pkg::COORD_W;
	localparam int DW = rclr_pkg::DELTA_W;
	localparam int EW = rclr_pkg::ERR_W;
	// doubled error term
	localparam int E2W = rclr_pkg::ERR_W + 1;

	// line state
	logic signed [CW-1:0] cur_x_q, cur_y_q, target_x_q, target_y_q;
	logic signed [DW-1:0] delta_x_q, delta_y_neg_q;
	logic                 step_x_neg_q, step_y_neg_q;
	logic signed [EW-1:0] error_term_q;
	logic                 line_active_q;
	logic [rclr_pkg::GRAY_W-1:0] line_gray_q;

	logic valid_s1, last_s1;

	logic              out_valid_q;
	rclr_pkg::pixel_t  pixel_q;
	rclr_pkg::pixel_t  pixel_c;

	logic advance, in_acc, is_start;

	// start path
	logic signed [DW-1:0] dx_c, dy_c, abs_dx_c, neg_dy_c;
	logic                 start_done_c;

	// step path
	logic signed [E2W-1:0] e2_c;
	logic                  move_x_c, move_y_c;
	logic signed [EW-1:0]  err_next_c;
	logic signed [CW-1:0]  x_next_c, y_next_c;
	logic                  step_done_c;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;
	assign is_start = (command == rclr_pkg::CMD_START);

	always_comb begin
		dx_c         = DW'(end_x) - DW'(start_x);
		dy_c         = DW'(end_y) - DW'(start_y);
		abs_dx_c     = dx_c[DW-1] ? -dx_c : dx_c;
		neg_dy_c     = dy_c[DW-1] ? dy_c : -dy_c;
		start_done_c = (start_x == end_x) && (start_y == end_y);
	end

	always_comb begin
		e2_c       = {error_term_q, 1'b0};
		move_x_c   = (e2_c >= E2W'(delta_y_neg_q));
		move_y_c   = (e2_c <= E2W'(delta_x_q));
		err_next_c = error_term_q
			+ (move_x_c ? EW'(delta_y_neg_q) : '0)
			+ (move_y_c ? EW'(delta_x_q) : '0);
		x_next_c = cur_x_q;
		y_next_c = cur_y_q;
		if (move_x_c) begin
			x_next_c = step_x_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
		end
		if (move_y_c) begin
			y_next_c = step_y_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
		end
		step_done_c = (x_next_c == target_x_q) && (y_next_c == target_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			target_x_q    <= '0;
			target_y_q    <= '0;
			delta_x_q     <= '0;
			delta_y_neg_q <= '0;
			step_x_neg_q  <= 1'b0;
			step_y_neg_q  <= 1'b0;
			error_term_q  <= '0;
			line_active_q <= 1'b0;
			line_gray_q   <= '0;
			valid_s1      <= 1'b0;
			last_s1       <= 1'b0;
		end else if (in_acc) begin
			if (is_start) begin
				cur_x_q       <= start_x;
				cur_y_q       <= start_y;
				target_x_q    <= end_x;
				target_y_q    <= end_y;
				delta_x_q     <= abs_dx_c;
				delta_y_neg_q <= neg_dy_c;
				step_x_neg_q  <= !(start_x < end_x);
				step_y_neg_q  <= !(start_y < end_y);
				error_term_q  <= EW'(abs_dx_c) + EW'(neg_dy_c);
				line_gray_q   <= color;
				line_active_q <= !start_done_c;
				valid_s1      <= 1'b1;
				last_s1       <= start_done_c;
			end else if (line_active_q) begin
				cur_x_q       <= x_next_c;
				cur_y_q       <= y_next_c;
				error_term_q  <= err_next_c;
				line_active_q <= !step_done_c;
				valid_s1      <= 1'b1;
				last_s1       <= step_done_c;
			end else begin
				// step on an idle line gives no word
				valid_s1 <= 1'b0;
			end
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 state still holds the point of the word in valid_s1
	rclr_panel_map #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT)
	) u_map (
		.cur_x     (cur_x_q),
		.cur_y     (cur_y_q),
		.line_gray (line_gray_q),
		.last      (last_s1),
		.pixel     (pixel_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			pixel_q <= pixel_c;
		end
	end

	assign out_valid = out_valid_q;
	assign panel_x   = pixel_q.panel_x;
	assign panel_y   = pixel_q.panel_y;
	assign gray      = pixel_q.gray;
	assign on_panel  = pixel_q.on_panel;
	assign last      = pixel_q.last;

	`RCLR_ASSERT_NOW(a_stall_only_when_full, in_stall, valid_s1 && out_valid_q,
		"input stalled with no pixel held")
	`RCLR_ASSERT_NEXT(a_idle_step_silent,
		in_acc && !is_start && !line_active_q, !valid_s1,
		"step on idle line produced a pixel")
	`RCLR_ASSERT_NOW(a_last_ends_line, valid_s1 && last_s1, !line_active_q,
		"line still active after its endpoint")
	`RCLR_ASSERT_NOW(a_off_panel_zero, out_valid_q && !pixel_q.on_panel,
		pixel_q.panel_x == '0 && pixel_q.panel_y == '0,
		"off-panel pixel with nonzero coordinates")

endmodule

[tb/rotated_clipped_line_raster_tb.sv]
`timescale 1ns / 1ps

module rotated_clipped_line_raster_tb;

	localparam int PANEL_W = rclr_pkg::PANEL_WIDTH_DEF;
	localparam int PANEL_H = rclr_pkg::PANEL_HEIGHT_DEF;
	localparam int RANDOM_WORDS = 1650;

	typedef struct {
		rclr_pkg::cmd_t                      cmd;
		logic signed [rclr_pkg::COORD_W-1:0] sx;
		logic signed [rclr_pkg::COORD_W-1:0] sy;
		logic signed [rclr_pkg::COORD_W-1:0] ex;
		logic signed [rclr_pkg::COORD_W-1:0] ey;
		logic [rclr_pkg::GRAY_W-1:0]         col;
	} line_word_t;

	typedef enum {BY_MODEL, TYPED_PIXEL, TYPED_NONE} row_check_t;

	typedef struct {
		line_word_t         w;
		row_check_t         chk;
		rclr_pkg::pixel_t   pix;
	} dir_row_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_stall;
	logic                               command;
	logic signed [rclr_pkg::COORD_W-1:0] start_x;
	logic signed [rclr_pkg::COORD_W-1:0] start_y;
	logic signed [rclr_pkg::COORD_W-1:0] end_x;
	logic signed [rclr_pkg::COORD_W-1:0] end_y;
	logic [rclr_pkg::GRAY_W-1:0]        color;
	logic                               out_valid;
	logic                               out_stall;
	logic [rclr_pkg::PANEL_COORD_W-1:0] panel_x;
	logic [rclr_pkg::PANEL_COORD_W-1:0] panel_y;
	logic [rclr_pkg::GRAY_W-1:0]        gray;
	logic                               on_panel;
	logic                               last;

	rotated_clipped_line_raster #(
		.PANEL_WIDTH (PANEL_W),
		.PANEL_HEIGHT(PANEL_H)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.start_x  (start_x),
		.start_y  (start_y),
		.end_x    (end_x),
		.end_y    (end_y),
		.color    (color),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.panel_x  (panel_x),
		.panel_y  (panel_y),
		.gray     (gray),
		.on_panel (on_panel),
		.last     (last)
	);

	// predictor copy of the line state
	logic signed [rclr_pkg::COORD_W-1:0] ln_x, ln_y, ln_tx, ln_ty;
	logic [rclr_pkg::DELTA_W-1:0]        ln_dx;
	logic signed [rclr_pkg::DELTA_W-1:0] ln_dyn;
	logic                                ln_sxn, ln_syn;
	logic signed [rclr_pkg::ERR_W-1:0]   ln_err;
	logic                                ln_active;
	logic [rclr_pkg::GRAY_W-1:0]         ln_gray;

	rclr_pkg::pixel_t pending_pixels[$];
	dir_row_t         dir_rows[$];

	int  errors = 0;
	int  words_in = 0;
	int  idle_steps = 0;
	int  pixels_predicted = 0;
	int  pixels_seen = 0;
	int  off_panel_seen = 0;
	int  lines_started = 0;
	bit  tx_idling = 1;
	bit  rx_idling = 1;
	bit  squeeze_req = 0;
	bit  squeeze_done = 0;
	int  hold_left = 0;
	int  run_left = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#8_000_000;
		$display("timeout: %0d pixels still pending", pending_pixels.size());
		$display("== FAIL ==");
		$finish;
	end

	function automatic int burst_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic bit raster_advance(input line_word_t w, output rclr_pkg::pixel_t pix);
		int  dx, dy, dxa, dyn, err, e2, px, py;
		bit  done, on;
		if (w.cmd == rclr_pkg::CMD_START) begin
			ln_x    = w.sx;
			ln_y    = w.sy;
			ln_tx   = w.ex;
			ln_ty   = w.ey;
			ln_gray = w.col;
			dx      = int'(w.ex) - int'(w.sx);
			dy      = int'(w.ey) - int'(w.sy);
			dxa     = (dx < 0) ? -dx : dx;
			dyn     = (dy < 0) ? dy : -dy;
			err     = dxa + dyn;
			ln_dx   = dxa[rclr_pkg::DELTA_W-1:0];
			ln_dyn  = dyn[rclr_pkg::DELTA_W-1:0];
			ln_sxn  = !(w.sx < w.ex);
			ln_syn  = !(w.sy < w.ey);
			ln_err  = err[rclr_pkg::ERR_W-1:0];
			done    = (ln_x == ln_tx) && (ln_y == ln_ty);
			ln_active = !done;
		end else begin
			if (!ln_active) begin
				pix = '0;
				return 1'b0;
			end
			dxa = ln_dx;
			dyn = ln_dyn;
			err = ln_err;
			e2  = 2 * err;
			if (e2 >= dyn) begin
				err  = err + dyn;
				ln_x = ln_sxn ? ln_x - 16'sd1 : ln_x + 16'sd1;
			end
			if (e2 <= dxa) begin
				err  = err + dxa;
				ln_y = ln_syn ? ln_y - 16'sd1 : ln_y + 16'sd1;
			end
			ln_err = err[rclr_pkg::ERR_W-1:0];
			done   = (ln_x == ln_tx) && (ln_y == ln_ty);
			if (done)
				ln_active = 1'b0;
		end
		// rotated mapping at full precision
		px = PANEL_W - 1 - int'(ln_y);
		py = int'(ln_x);
		on = (px >= 0) && (px < PANEL_W) && (py >= 0) && (py < PANEL_H);
		pix.panel_x  = on ? px[rclr_pkg::PANEL_COORD_W-1:0] : '0;
		pix.panel_y  = on ? py[rclr_pkg::PANEL_COORD_W-1:0] : '0;
		pix.gray     = ln_gray & rclr_pkg::GRAY_MASK;
		pix.on_panel = on;
		pix.last     = done;
		return 1'b1;
	endfunction

	task automatic push_word(input line_word_t w, input row_check_t chk,
			input rclr_pkg::pixel_t typed);
		rclr_pkg::pixel_t pix;
		bit     got;
		int     n;
		@(negedge clk);
		in_valid <= 1'b1;
		command  <= w.cmd;
		start_x  <= w.sx;
		start_y  <= w.sy;
		end_x    <= w.ex;
		end_y    <= w.ey;
		color    <= w.col;
		do @(posedge clk); while (in_stall);
		got = raster_advance(w, pix);
		words_in++;
		if (w.cmd == rclr_pkg::CMD_START)
			lines_started++;
		if (got)
			pixels_predicted++;
		else
			idle_steps++;
		case (chk)
			BY_MODEL: begin
				if (got)
					pending_pixels.push_back(pix);
			end
			TYPED_PIXEL: pending_pixels.push_back(typed);
			default: ;
		endcase
		if (tx_idling) begin
			n = burst_len();
			if (n > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	endtask

	function automatic line_word_t rand_word(input rclr_pkg::cmd_t cmd);
		line_word_t w;
		w.cmd = cmd;
		w.sx  = 16'($urandom);
		w.sy  = 16'($urandom);
		w.ex  = 16'($urandom);
		w.ey  = 16'($urandom);
		w.col = 8'($urandom);
		return w;
	endfunction

	task automatic send_line(input int sx, input int sy, input int ex, input int ey,
			input int nsteps);
		line_word_t w;
		w     = rand_word(rclr_pkg::CMD_START);
		w.sx  = 16'(sx);
		w.sy  = 16'(sy);
		w.ex  = 16'(ex);
		w.ey  = 16'(ey);
		push_word(w, BY_MODEL, '0);
		repeat (nsteps) push_word(rand_word(rclr_pkg::CMD_STEP), BY_MODEL, '0);
	endtask

	task automatic add_row(input rclr_pkg::cmd_t cmd, input int sx, input int sy,
			input int ex, input int ey, input int col, input row_check_t chk,
			input rclr_pkg::pixel_t pix);
		dir_row_t r;
		r.w.cmd = cmd;
		r.w.sx  = 16'(sx);
		r.w.sy  = 16'(sy);
		r.w.ex  = 16'(ex);
		r.w.ey  = 16'(ey);
		r.w.col = 8'(col);
		r.chk   = chk;
		r.pix   = pix;
		dir_rows.push_back(r);
	endtask

	task automatic cmp_field(input string name, input int e, input int a);
		if (e != a) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, e, a);
			errors++;
		end
	endtask

	// receiver: random stall runs, plus one long hold-off on request
	always @(negedge clk) begin
		if (squeeze_req && !squeeze_done) begin
			hold_left    = 300;
			squeeze_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (!rx_idling) begin
			out_stall <= 1'b0;
		end else if (run_left > 0) begin
			run_left--;
		end else begin
			out_stall <= ($urandom_range(0, 2) == 0);
			run_left = burst_len();
		end
	end

	always @(posedge clk) begin
		rclr_pkg::pixel_t exp_pix;
		if (arst_n && out_valid && !out_stall) begin
			pixels_seen++;
			if (!on_panel)
				off_panel_seen++;
			if (pending_pixels.size() == 0) begin
				$display("%0t ns: pixel with none expected, got x=%0d y=%0d",
					$time, panel_x, panel_y);
				$display("  gray=%0h on=%0b last=%0b", gray, on_panel, last);
				errors++;
			end else begin
				exp_pix = pending_pixels.pop_front();
				cmp_field("panel_x", exp_pix.panel_x, panel_x);
				cmp_field("panel_y", exp_pix.panel_y, panel_y);
				cmp_field("gray", exp_pix.gray, gray);
				cmp_field("on_panel", exp_pix.on_panel, on_panel);
				cmp_field("last", exp_pix.last, last);
			end
		end
	end

	initial begin
		int goal, sx, sy, dx, dy, n, r, ax, ay;
		bit quiet;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		command  = rclr_pkg::CMD_STEP;
		start_x  = '0;
		start_y  = '0;
		end_x    = '0;
		end_y    = '0;
		color    = '0;
		out_stall = 1'b0;
		ln_x = '0; ln_y = '0; ln_tx = '0; ln_ty = '0;
		ln_dx = '0; ln_dyn = '0; ln_sxn = 1'b0; ln_syn = 1'b0;
		ln_err = '0; ln_active = 1'b0; ln_gray = '0;

		// step while idle after reset
		add_row(rclr_pkg::CMD_STEP, 0, 0, 0, 0, 0, TYPED_NONE, '0);
		// zero-length line at the origin
		add_row(rclr_pkg::CMD_START, 0, 0, 0, 0, 8'hFF, TYPED_PIXEL,
			rclr_pkg::pixel_t'{10'd959, 10'd0, 8'hF0, 1'b1, 1'b1});
		add_row(rclr_pkg::CMD_STEP, 0, 0, 0, 0, 0, TYPED_NONE, '0);
		add_row(rclr_pkg::CMD_START, 0, 0, 3, 1, 8'h5A, BY_MODEL, '0);
		repeat (3) add_row(rclr_pkg::CMD_STEP, 0, 0, 0, 0, 0, BY_MODEL, '0);
		// step past the endpoint
		add_row(rclr_pkg::CMD_STEP, 0, 0, 0, 0, 0, TYPED_NONE, '0);
		// full-range diagonal, dropped after two steps
		add_row(rclr_pkg::CMD_START, -32768, -32768, 32767, 32767, 8'h0F, TYPED_PIXEL,
			rclr_pkg::pixel_t'{10'd0, 10'd0, 8'h00, 1'b0, 1'b0});
		repeat (2) add_row(rclr_pkg::CMD_STEP, 0, 0, 0, 0, 0, BY_MODEL, '0);
		add_row(rclr_pkg::CMD_START, 32767, 32767, 32767, 32767, 8'hFF, TYPED_PIXEL,
			rclr_pkg::pixel_t'{10'd0, 10'd0, 8'hF0, 1'b0, 1'b1});
		// panel corners and just outside them
		add_row(rclr_pkg::CMD_START, 539, 0, 539, 0, 8'h37, TYPED_PIXEL,
			rclr_pkg::pixel_t'{10'd959, 10'd539, 8'h30, 1'b1, 1'b1});
		add_row(rclr_pkg::CMD_START, 0, 959, 0, 959, 8'hC4, TYPED_PIXEL,
			rclr_pkg::pixel_t'{10'd0, 10'd0, 8'hC0, 1'b1, 1'b1});
		add_row(rclr_pkg::CMD_START, 540, 0, 540, 0, 8'h80, TYPED_PIXEL,
			rclr_pkg::pixel_t'{10'd0, 10'd0, 8'h80, 1'b0, 1'b1});
		add_row(rclr_pkg::CMD_START, 0, 960, 0, 960, 8'h01, TYPED_PIXEL,
			rclr_pkg::pixel_t'{10'd0, 10'd0, 8'h00, 1'b0, 1'b1});
		add_row(rclr_pkg::CMD_START, -1, -1, -1, -1, 8'hFE, TYPED_PIXEL,
			rclr_pkg::pixel_t'{10'd0, 10'd0, 8'hF0, 1'b0, 1'b1});
		// line crossing the panel edge, then a steep one
		add_row(rclr_pkg::CMD_START, 0, 959, -2, 962, 8'hA5, BY_MODEL, '0);
		repeat (3) add_row(rclr_pkg::CMD_STEP, 0, 0, 0, 0, 0, BY_MODEL, '0);
		add_row(rclr_pkg::CMD_START, 5, 5, 6, 8, 8'h69, BY_MODEL, '0);
		repeat (3) add_row(rclr_pkg::CMD_STEP, 0, 0, 0, 0, 0, BY_MODEL, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			push_word(dir_rows[i].w, dir_rows[i].chk, dir_rows[i].pix);

		goal = words_in + RANDOM_WORDS;
		while (words_in < goal) begin
			quiet = ((words_in / 100) % 5) == 2;
			tx_idling = !quiet;
			rx_idling = !quiet;
			if (!squeeze_done && words_in > goal - RANDOM_WORDS / 2) begin
				// long receiver hold-off with the sender running flat out
				tx_idling   = 1'b0;
				squeeze_req = 1'b1;
				send_line(100, 300, 110, 360, 60);
				continue;
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				sx = $urandom_range(0, 572) - 16;
				sy = $urandom_range(0, 992) - 16;
				dx = $urandom_range(0, 48) - 24;
				dy = $urandom_range(0, 48) - 24;
				if ($urandom_range(0, 9) == 0)
					dx = 0;
				else if ($urandom_range(0, 9) == 0)
					dy = 0;
				ax = (dx < 0) ? -dx : dx;
				ay = (dy < 0) ? -dy : dy;
				n  = (ax > ay) ? ax : ay;
				r  = $urandom_range(0, 99);
				if (r < 15)
					n = n + $urandom_range(1, 2);
				else if (r < 30)
					n = $urandom_range(0, n);
				send_line(sx, sy, sx + dx, sy + dy, n);
			end else if (r < 85) begin
				sx = $signed(16'($urandom));
				sy = $signed(16'($urandom));
				send_line(sx, sy, $signed(16'($urandom)), $signed(16'($urandom)),
					$urandom_range(0, 4));
			end else if (r < 95) begin
				repeat ($urandom_range(1, 3))
					push_word(rand_word(rclr_pkg::CMD_STEP), BY_MODEL, '0);
			end else begin
				sx = $urandom_range(0, 572) - 16;
				sy = $urandom_range(0, 992) - 16;
				send_line(sx, sy, sx, sy, $urandom_range(0, 1));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d words accepted: %0d lines started, %0d steps on idle block",
			words_in, lines_started, idle_steps);
		$display("%0d pixels checked, %0d of them off panel", pixels_seen, off_panel_seen);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
